/* hw/rtl/fbfla_pkg.sv */
// Package for the fixed-size block pool allocator.
// Holds field widths, request mode codes and register indexes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbfla_pkg;

	localparam int MODE_W    = 2;
	localparam int IDX_W     = 8;
	localparam int OFFSET_W  = 20;
	localparam int COUNT_W   = 9;
	localparam int BYTES_W   = 13;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 13;

	localparam logic [COUNT_W-1:0] BLOCKS_RESET = 9'd256;
	localparam logic [BYTES_W-1:0] BYTES_RESET  = 13'd64;
	localparam logic [BYTES_W-1:0] BYTES_MIN    = 13'd8;
	localparam logic [BYTES_W-1:0] BYTES_MAX    = 13'd4096;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FREE  = 2'd1,
		MODE_RESET = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCKS = 1'd0,
		CFG_BYTES  = 1'd1
	} cfg_reg_t;

endpackage

`default_nettype wire

/* hw/rtl/fbfla_req_if.sv */
// Request channel of the block pool allocator: valid/ready plus request fields.
// Depends on fbfla_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fbfla_req_if;
	logic                           valid;
	logic                           ready;
	logic [fbfla_pkg::MODE_W-1:0]   mode;
	logic [fbfla_pkg::IDX_W-1:0]    block_index;

	modport source (output valid, output mode, output block_index, input ready);
	modport sink   (input valid, input mode, input block_index, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fbfla_rsp_if.sv */
// Result channel of the block pool allocator: valid/ready plus result fields.
// Depends on fbfla_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fbfla_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            ok;
	logic [fbfla_pkg::IDX_W-1:0]     granted_index;
	logic [fbfla_pkg::OFFSET_W-1:0]  granted_offset;
	logic [fbfla_pkg::COUNT_W-1:0]   used_count;
	logic                            pool_full;
	logic                            pool_empty;

	modport source (output valid, output ok, output granted_index, output granted_offset,
		output used_count, output pool_full, output pool_empty, input ready);
	modport sink   (input valid, input ok, input granted_index, input granted_offset,
		input used_count, input pool_full, input pool_empty, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fixed_block_free_list_allocator_unit.sv */
// Top level of the fixed-size block pool allocator.
// Depends on fbfla_pkg, fbfla_req_if and fbfla_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

// The block hands out and takes back equal-size blocks of a pool through a
// linked free list held in a synchronous next-link memory of MAX_BLOCKS
// entries, plus a head index and a used count in registers. Every request
// transaction gives exactly one result transaction. An allocate reads the
// next-link memory on the pop and then passes through ST_ALLOC, where the
// head is loaded from the registered read data. A free writes the old head
// into the freed entry and moves the head. A pool reset request answers at
// once and then relinks the memory in index order, one entry a cycle, so the
// next request waits for all MAX_BLOCKS entries. After arst_n and after
// every configuration write the same relinking pass over every entry runs
// before the first request is taken; configuration writes are taken at any
// time and restart it. A finished result waits in an output register, and a
// new request may enter in the cycle that result is taken. A block count of
// zero refuses every request; a count above MAX_BLOCKS acts as MAX_BLOCKS and
// the block size is clamped to 8..4096 bytes for the offset.
module fixed_block_free_list_allocator_unit #(
	parameter int MAX_BLOCKS = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	fbfla_req_if.sink                              req,
	fbfla_rsp_if.source                            rsp,
	input  wire logic                              cfg_we,
	input  wire logic [fbfla_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fbfla_pkg::CFG_W-1:0]       cfg_wdata
);
	import fbfla_pkg::*;

	localparam int IW     = $clog2(MAX_BLOCKS);
	localparam int IW_EXT = (IW > IDX_W) ? IW : IDX_W;
	localparam int PROD_W = IW_EXT + BYTES_W;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_ALLOC = 3'b100
	} state_t;

	// Control and configuration registers
	state_t               state_q;
	logic [IW-1:0]        clr_q;
	logic [IW-1:0]        head_q;
	logic [COUNT_W-1:0]   used_q;
	logic [COUNT_W-1:0]   blocks_q;
	logic [BYTES_W-1:0]   bytes_q;

	// Output register
	logic                 out_valid_q;
	logic                 out_ok_q;
	logic [IDX_W-1:0]     out_index_q;
	logic [OFFSET_W-1:0]  out_offset_q;
	logic [COUNT_W-1:0]   out_used_q;
	logic                 out_full_q;
	logic                 out_empty_q;

	// Next-link memory
	logic [IW-1:0]        link_mem [MAX_BLOCKS];
	logic [IW-1:0]        rd_data_q;

	logic                 accept;
	logic [COUNT_W-1:0]   count_eff;
	logic [BYTES_W-1:0]   bytes_eff;
	logic                 do_alloc;
	logic                 do_free;
	logic                 do_reset;
	logic [COUNT_W-1:0]   used_nxt;
	logic [IW_EXT-1:0]    head_ext;
	logic [IW_EXT-1:0]    idx_ext;
	logic [IW-1:0]        free_addr;
	logic [PROD_W-1:0]    offset_prod;
	logic                 clr_last;
	logic [IW-1:0]        clr_link;
	logic                 mem_we;
	logic [IW-1:0]        mem_waddr;
	logic [IW-1:0]        mem_wdata;

	// Take a request only when idle and the output register is free or draining
	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	// Clamp the block count to the memory depth
	assign count_eff = (32'(blocks_q) > MAX_BLOCKS) ? COUNT_W'(MAX_BLOCKS) : blocks_q;

	always_comb begin
		if (bytes_q < BYTES_MIN) begin
			bytes_eff = BYTES_MIN;
		end else if (bytes_q > BYTES_MAX) begin
			bytes_eff = BYTES_MAX;
		end else begin
			bytes_eff = bytes_q;
		end
	end

	assign head_ext  = IW_EXT'(head_q);
	assign idx_ext   = IW_EXT'(req.block_index);
	assign free_addr = idx_ext[IW-1:0];

	// Decide the outcome of the request on the handshake lines
	always_comb begin
		do_alloc = 1'b0;
		do_free  = 1'b0;
		do_reset = 1'b0;
		if (count_eff != '0) begin
			case (req.mode)
				MODE_ALLOC: do_alloc = (used_q < count_eff);
				MODE_FREE:  do_free  = (used_q != '0) && (COUNT_W'(req.block_index) < count_eff);
				MODE_RESET: do_reset = 1'b1;
				default:    ;
			endcase
		end
	end

	always_comb begin
		if (do_reset) begin
			used_nxt = '0;
		end else if (do_alloc) begin
			used_nxt = used_q + 1'b1;
		end else if (do_free) begin
			used_nxt = used_q - 1'b1;
		end else begin
			used_nxt = used_q;
		end
	end

	assign offset_prod = head_ext * PROD_W'(bytes_eff);

	// Relinking pass: entry i links to i+1, the last one back to 0
	assign clr_last = (clr_q == IW'(MAX_BLOCKS - 1));
	assign clr_link = clr_last ? '0 : clr_q + 1'b1;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = clr_link;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (accept && do_free) begin
			mem_we    = 1'b1;
			mem_waddr = free_addr;
			mem_wdata = head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		// Fetch the link behind the head on a pop
		if (accept && do_alloc) begin
			rd_data_q <= link_mem[head_q];
		end
	end

	// Control state, head and used count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			head_q   <= '0;
			used_q   <= '0;
			blocks_q <= BLOCKS_RESET;
			bytes_q  <= BYTES_RESET;
		end else if (cfg_we) begin
			// Pool set-up: take the register and relink from scratch
			case (cfg_index)
				CFG_BLOCKS: blocks_q <= cfg_wdata[COUNT_W-1:0];
				CFG_BYTES:  bytes_q  <= cfg_wdata[BYTES_W-1:0];
				default:    ;
			endcase
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			head_q  <= '0;
			used_q  <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_last) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						used_q <= used_nxt;
						if (do_alloc) begin
							state_q <= ST_ALLOC;
						end else if (do_free) begin
							head_q <= free_addr;
						end else if (do_reset) begin
							head_q  <= '0;
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_ALLOC: begin
					// Advance the head to the fetched link
					head_q  <= rd_data_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// Output register valid: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_ok_q     <= do_alloc || do_free || do_reset;
			out_index_q  <= do_alloc ? head_ext[IDX_W-1:0] : '0;
			out_offset_q <= do_alloc ? offset_prod[OFFSET_W-1:0] : '0;
			out_used_q   <= used_nxt;
			out_full_q   <= (used_nxt == count_eff);
			out_empty_q  <= (used_nxt == '0);
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.ok             = out_ok_q;
	assign rsp.granted_index  = out_index_q;
	assign rsp.granted_offset = out_offset_q;
	assign rsp.used_count     = out_used_q;
	assign rsp.pool_full      = out_full_q;
	assign rsp.pool_empty     = out_empty_q;

endmodule

`default_nettype wire

/* hw/rtl/fbfla_checker.sv */
// Port-level checks for the block pool allocator, bound to the top level.
// Depends on fbfla_pkg and fixed_block_free_list_allocator_unit.
`timescale 1ns / 1ps
`default_nettype none

module fbfla_port_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic                              ok,
	input wire logic [fbfla_pkg::IDX_W-1:0]       granted_index,
	input wire logic [fbfla_pkg::OFFSET_W-1:0]    granted_offset,
	input wire logic [fbfla_pkg::COUNT_W-1:0]     used_count,
	input wire logic                              pool_full,
	input wire logic                              pool_empty
);
	import fbfla_pkg::*;

	// Hold a stalled result
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(ok) && $stable(granted_index)
			&& $stable(granted_offset) && $stable(used_count)
			&& $stable(pool_full) && $stable(pool_empty))
		else $error("result changed while stalled");

	// A refused result carries no grant
	a_refused_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> granted_index == '0 && granted_offset == '0)
		else $error("refused transaction shows a grant");

	// Empty flag follows the used count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pool_empty == (used_count == '0))
		else $error("empty flag disagrees with used count");

endmodule

bind fixed_block_free_list_allocator_unit fbfla_port_checker u_fbfla_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (rsp.valid),
	.out_ready      (rsp.ready),
	.ok             (rsp.ok),
	.granted_index  (rsp.granted_index),
	.granted_offset (rsp.granted_offset),
	.used_count     (rsp.used_count),
	.pool_full      (rsp.pool_full),
	.pool_empty     (rsp.pool_empty)
);

`default_nettype wire
